// ===== hw/rtl/bra_pkg.sv =====
// Shared types, codes and helpers of the resource allocator.
package bra_pkg;

	// Fixed field widths of the command and result transactions
	localparam int PID_W       = 3;
	localparam int AMT_W       = 8;
	localparam int NUM_AMT     = 5;
	localparam int MAX_RESULTS = 33;
	localparam int RES_CNT_W   = 6;

	typedef enum logic [2:0] {
		OP_SET_FREE = 3'd0,
		OP_LOAD_MAX = 3'd1,
		OP_LOAD_HELD = 3'd2,
		OP_CHECK = 3'd3,
		OP_REQUEST = 3'd4,
		OP_RELEASE = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_LOADED = 4'd0,
		ST_SAFE = 4'd1,
		ST_UNSAFE = 4'd2,
		ST_INVALID = 4'd3,
		ST_GRANTED = 4'd4,
		ST_QUEUED = 4'd5,
		ST_QUEUE_FULL = 4'd6,
		ST_RELEASED = 4'd7,
		ST_REL_INVALID = 4'd8,
		ST_FROM_QUEUE = 4'd9,
		ST_UNKNOWN = 4'd10,
		ST_ROLLED_QUEUED = 4'd11
	} status_t;

	typedef struct packed {
		logic [2:0]       operation;
		logic [PID_W-1:0] process_id;
		logic [AMT_W-1:0] amount_0;
		logic [AMT_W-1:0] amount_1;
		logic [AMT_W-1:0] amount_2;
		logic [AMT_W-1:0] amount_3;
		logic [AMT_W-1:0] amount_4;
	} cmd_t;

	typedef struct packed {
		logic [3:0]       status;
		logic [PID_W-1:0] subject_id;
		logic [PID_W-1:0] seq_id;
		logic             seq_valid;
		logic             last;
	} result_t;

	// Lane compare flags of the row unit
	typedef struct packed {
		logic a_le_need;
		logic a_le_held;
		logic a_le_w;
		logic need_le_w;
	} row_flags_t;

	function automatic result_t make_result(status_t st, logic [PID_W-1:0] subj,
			logic [PID_W-1:0] seq, logic v);
		result_t r;
		r.status     = st;
		r.subject_id = subj;
		r.seq_id     = seq;
		r.seq_valid  = v;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// ===== hw/rtl/bankers_resource_allocator.sv =====
// Top level: Banker's algorithm allocator with a row-at-a-time sequencer.
//
//  channel   handshake                 payload
//  command   start in, busy out        cmd (cmd_t)
//  result    result_valid out (strobe) result (result_t)
//
// A command is taken when start is high and busy is low. A command without a
// scan is busy through S_EXEC and S_FINISH, and its result leaves the result
// stage when the command ends. A safety check scans one member row per cycle
// through the shared row unit, up to NPROC*(NPROC+1)/2 + NPROC - 1 rows, then
// emits one result per sequence position; a release repeats this for each
// queued request that fits the free resources. Results of one sequence come
// on consecutive cycles, the last result of a command is marked, and the
// receiver cannot hold them off. Reset clears all tables and counts.
module bankers_resource_allocator #(
	parameter int NPROC = 8,
	parameter int NRES = 5,
	parameter int WAIT_DEPTH = 4,
	parameter int UNIT_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bra_pkg::cmd_t     cmd,
	output logic              result_valid,
	output bra_pkg::result_t  result
);
	import bra_pkg::*;

	localparam int FW  = UNIT_BITS + 2;
	localparam int PIW = $clog2(NPROC);
	localparam int CW  = $clog2(NPROC + 1);
	localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WCW = $clog2(WAIT_DEPTH + 1);

	typedef logic [NRES-1:0][UNIT_BITS-1:0] row_t;
	typedef logic [NRES-1:0][FW-1:0]        wrow_t;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SAFE_INIT, S_SCAN, S_SAFE_DONE, S_SEQ, S_RETRY, S_FINISH
	} state_t;

	typedef enum logic [1:0] {CTX_CHECK, CTX_REQ, CTX_RETRY} ctx_t;

	state_t            state_q;
	state_t            seq_ret_q;
	ctx_t              ctx_q;
	logic [2:0]        op_q;
	logic [PID_W-1:0]  pid_q;
	row_t              amt_q;
	wrow_t             free_q;
	row_t              max_q [NPROC];
	row_t              held_q [NPROC];
	logic [PID_W-1:0]  member_q [NPROC];
	logic [NPROC-1:0]  is_mem_q;
	logic [CW-1:0]     mcount_q;
	logic [PID_W-1:0]  wait_pid_q [WAIT_DEPTH];
	row_t              wait_amt_q [WAIT_DEPTH];
	logic [WCW-1:0]    wcount_q;
	logic [WCW-1:0]    widx_q;
	wrow_t             work_q;
	logic [NPROC-1:0]  fin_q;
	logic [PID_W-1:0]  seq_q [NPROC];
	logic [CW-1:0]     slen_q;
	logic [PIW-1:0]    j_q;
	logic [PIW-1:0]    k_q;
	logic              safe_q;
	logic [PID_W-1:0]  gpid_q;
	row_t              gamt_q;
	status_t           emit_st_q;
	logic [PID_W-1:0]  emit_subj_q;
	logic              push_q;
	result_t           pres_q;
	logic              flush_q;

	row_t              a_in;
	logic [AMT_W-1:0]  amt8 [NUM_AMT];
	logic [PIW-1:0]    row_idx;
	logic [PIW-1:0]    pidx;
	row_t              a_sel;
	wrow_t             w_sel;
	row_flags_t        flags;
	wrow_t             w_plus_held;
	wrow_t             w_plus_a;
	wrow_t             w_minus_a;
	row_t              held_plus_a;
	row_t              held_minus_a;
	logic [WAW-1:0]    widx;

	assign busy = (state_q != S_IDLE);
	assign pidx = PIW'(pid_q);
	assign widx = widx_q[WAW-1:0];

	// Mask the command amounts to the unit width
	always_comb begin
		amt8[0] = cmd.amount_0;
		amt8[1] = cmd.amount_1;
		amt8[2] = cmd.amount_2;
		amt8[3] = cmd.amount_3;
		amt8[4] = cmd.amount_4;
		for (int r = 0; r < NRES; r++) begin
			a_in[r] = UNIT_BITS'(amt8[r]);
		end
	end

	// Steer the shared row unit by sequencer state
	always_comb begin
		unique case (state_q)
			S_SCAN: begin
				row_idx = PIW'(member_q[j_q]);
				a_sel   = amt_q;
				w_sel   = work_q;
			end
			S_RETRY: begin
				row_idx = PIW'(wait_pid_q[widx]);
				a_sel   = wait_amt_q[widx];
				w_sel   = free_q;
			end
			S_SAFE_DONE: begin
				row_idx = PIW'(gpid_q);
				a_sel   = gamt_q;
				w_sel   = free_q;
			end
			default: begin
				row_idx = pidx;
				a_sel   = amt_q;
				w_sel   = free_q;
			end
		endcase
	end

	bra_row_unit #(.NRES(NRES), .UNIT_BITS(UNIT_BITS)) u_row (
		.max_row      (max_q[row_idx]),
		.held_row     (held_q[row_idx]),
		.a_row        (a_sel),
		.w_row        (w_sel),
		.flags        (flags),
		.w_plus_held  (w_plus_held),
		.w_plus_a     (w_plus_a),
		.w_minus_a    (w_minus_a),
		.held_plus_a  (held_plus_a),
		.held_minus_a (held_minus_a)
	);

	bra_result_stage u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_q),
		.push_res (pres_q),
		.flush    (flush_q),
		.valid    (result_valid),
		.res      (result)
	);

	// Sequencer: decode, safety scan, sequence emission, queue retry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_ret_q   <= S_FINISH;
			ctx_q       <= CTX_CHECK;
			op_q        <= '0;
			pid_q       <= '0;
			amt_q       <= '0;
			free_q      <= '0;
			max_q       <= '{default: '0};
			held_q      <= '{default: '0};
			member_q    <= '{default: '0};
			is_mem_q    <= '0;
			mcount_q    <= '0;
			wait_pid_q  <= '{default: '0};
			wait_amt_q  <= '{default: '0};
			wcount_q    <= '0;
			widx_q      <= '0;
			work_q      <= '0;
			fin_q       <= '0;
			seq_q       <= '{default: '0};
			slen_q      <= '0;
			j_q         <= '0;
			k_q         <= '0;
			safe_q      <= 1'b0;
			gpid_q      <= '0;
			gamt_q      <= '0;
			emit_st_q   <= ST_LOADED;
			emit_subj_q <= '0;
			push_q      <= 1'b0;
			pres_q      <= '0;
			flush_q     <= 1'b0;
		end else begin
			push_q  <= 1'b0;
			flush_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= cmd.operation;
						pid_q   <= cmd.process_id;
						amt_q   <= a_in;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FINISH;
					if (op_q == OP_SET_FREE) begin
						for (int r = 0; r < NRES; r++) free_q[r] <= FW'(amt_q[r]);
						push_q <= 1'b1;
						pres_q <= make_result(ST_LOADED, '0, '0, 1'b0);
					end else if (op_q == OP_CHECK) begin
						ctx_q   <= CTX_CHECK;
						state_q <= S_SAFE_INIT;
					end else if (op_q == OP_LOAD_MAX || op_q == OP_LOAD_HELD
							|| op_q == OP_REQUEST || op_q == OP_RELEASE) begin
						push_q <= 1'b1;
						if (int'(pid_q) >= NPROC) begin
							pres_q <= make_result(ST_UNKNOWN, pid_q, '0, 1'b0);
						end else if (op_q == OP_LOAD_MAX) begin
							max_q[pidx] <= amt_q;
							if (!is_mem_q[pidx]) begin
								is_mem_q[pidx] <= 1'b1;
								member_q[mcount_q[PIW-1:0]] <= pid_q;
								mcount_q <= mcount_q + CW'(1);
							end
							pres_q <= make_result(ST_LOADED, pid_q, '0, 1'b0);
						end else if (op_q == OP_LOAD_HELD) begin
							held_q[pidx] <= amt_q;
							pres_q <= make_result(ST_LOADED, pid_q, '0, 1'b0);
						end else if (!is_mem_q[pidx]) begin
							pres_q <= make_result(ST_UNKNOWN, pid_q, '0, 1'b0);
						end else if (op_q == OP_REQUEST) begin
							if (!flags.a_le_need) begin
								pres_q <= make_result(ST_INVALID, pid_q, '0, 1'b0);
							end else if (!flags.a_le_w) begin
								if (int'(wcount_q) < WAIT_DEPTH) begin
									wait_pid_q[wcount_q[WAW-1:0]] <= pid_q;
									wait_amt_q[wcount_q[WAW-1:0]] <= amt_q;
									wcount_q <= wcount_q + WCW'(1);
									pres_q <= make_result(ST_QUEUED, pid_q, '0, 1'b0);
								end else begin
									pres_q <= make_result(ST_QUEUE_FULL, pid_q, '0, 1'b0);
								end
							end else begin
								// tentatively grant, then prove safety
								push_q       <= 1'b0;
								free_q       <= w_minus_a;
								held_q[pidx] <= held_plus_a;
								gpid_q       <= pid_q;
								gamt_q       <= amt_q;
								ctx_q        <= CTX_REQ;
								state_q      <= S_SAFE_INIT;
							end
						end else begin
							if (!flags.a_le_held) begin
								pres_q <= make_result(ST_REL_INVALID, pid_q, '0, 1'b0);
							end else begin
								free_q       <= w_plus_a;
								held_q[pidx] <= held_minus_a;
								pres_q  <= make_result(ST_RELEASED, pid_q, '0, 1'b0);
								widx_q  <= '0;
								state_q <= S_RETRY;
							end
						end
					end
				end
				S_SAFE_INIT: begin
					work_q <= free_q;
					fin_q  <= '0;
					slen_q <= '0;
					j_q    <= '0;
					if (mcount_q == '0) begin
						safe_q  <= 1'b1;
						state_q <= S_SAFE_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// first unfinished member that fits finishes; rescan from the top
					if (!fin_q[j_q] && flags.need_le_w) begin
						fin_q[j_q]               <= 1'b1;
						seq_q[slen_q[PIW-1:0]]   <= member_q[j_q];
						slen_q                   <= slen_q + CW'(1);
						work_q                   <= w_plus_held;
						j_q                      <= '0;
						if ((slen_q + CW'(1)) == mcount_q) begin
							safe_q  <= 1'b1;
							state_q <= S_SAFE_DONE;
						end
					end else if ((CW'(j_q) + CW'(1)) == mcount_q) begin
						safe_q  <= 1'b0;
						state_q <= S_SAFE_DONE;
					end else begin
						j_q <= j_q + PIW'(1);
					end
				end
				S_SAFE_DONE: begin
					k_q <= '0;
					unique case (ctx_q)
						CTX_CHECK: begin
							if (safe_q) begin
								emit_st_q   <= ST_SAFE;
								emit_subj_q <= '0;
								seq_ret_q   <= S_FINISH;
								state_q     <= S_SEQ;
							end else begin
								push_q  <= 1'b1;
								pres_q  <= make_result(ST_UNSAFE, '0, '0, 1'b0);
								state_q <= S_FINISH;
							end
						end
						CTX_REQ: begin
							if (safe_q) begin
								emit_st_q   <= ST_GRANTED;
								emit_subj_q <= gpid_q;
								seq_ret_q   <= S_FINISH;
								state_q     <= S_SEQ;
							end else begin
								// roll back and queue the request if the wait queue has room
								free_q          <= w_plus_a;
								held_q[row_idx] <= held_minus_a;
								push_q          <= 1'b1;
								state_q         <= S_FINISH;
								if (int'(wcount_q) < WAIT_DEPTH) begin
									wait_pid_q[wcount_q[WAW-1:0]] <= gpid_q;
									wait_amt_q[wcount_q[WAW-1:0]] <= gamt_q;
									wcount_q <= wcount_q + WCW'(1);
									pres_q <= make_result(ST_ROLLED_QUEUED, gpid_q, '0, 1'b0);
								end else begin
									pres_q <= make_result(ST_QUEUE_FULL, gpid_q, '0, 1'b0);
								end
							end
						end
						default: begin
							if (safe_q) begin
								emit_st_q   <= ST_FROM_QUEUE;
								emit_subj_q <= gpid_q;
								seq_ret_q   <= S_RETRY;
								state_q     <= S_SEQ;
								for (int k = 0; k < WAIT_DEPTH - 1; k++) begin
									if (WCW'(k) >= widx_q) begin
										wait_pid_q[k] <= wait_pid_q[k+1];
										wait_amt_q[k] <= wait_amt_q[k+1];
									end
								end
								wcount_q <= wcount_q - WCW'(1);
							end else begin
								free_q          <= w_plus_a;
								held_q[row_idx] <= held_minus_a;
								widx_q          <= widx_q + WCW'(1);
								state_q         <= S_RETRY;
							end
						end
					endcase
				end
				S_SEQ: begin
					push_q <= 1'b1;
					if (slen_q == '0) begin
						pres_q  <= make_result(emit_st_q, emit_subj_q, '0, 1'b0);
						state_q <= seq_ret_q;
					end else begin
						pres_q <= make_result(emit_st_q, emit_subj_q, seq_q[k_q], 1'b1);
						k_q    <= k_q + PIW'(1);
						if ((CW'(k_q) + CW'(1)) == slen_q) state_q <= seq_ret_q;
					end
				end
				S_RETRY: begin
					if (widx_q >= wcount_q) begin
						state_q <= S_FINISH;
					end else if (!flags.a_le_need) begin
						// drop an entry that no longer fits its need
						push_q <= 1'b1;
						pres_q <= make_result(ST_INVALID, wait_pid_q[widx], '0, 1'b0);
						for (int k = 0; k < WAIT_DEPTH - 1; k++) begin
							if (WCW'(k) >= widx_q) begin
								wait_pid_q[k] <= wait_pid_q[k+1];
								wait_amt_q[k] <= wait_amt_q[k+1];
							end
						end
						wcount_q <= wcount_q - WCW'(1);
					end else if (flags.a_le_w) begin
						free_q          <= w_minus_a;
						held_q[row_idx] <= held_plus_a;
						gpid_q          <= wait_pid_q[widx];
						gamt_q          <= wait_amt_q[widx];
						ctx_q           <= CTX_RETRY;
						state_q         <= S_SAFE_INIT;
					end else begin
						widx_q <= widx_q + WCW'(1);
					end
				end
				default: begin
					flush_q <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wcount_q) <= WAIT_DEPTH)
		else $error("wait queue count beyond depth");

	a_seq_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.seq_valid) |-> (result.status == ST_SAFE
			|| result.status == ST_GRANTED || result.status == ST_FROM_QUEUE))
		else $error("sequence entry on a status without a sequence");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command taken without going busy");

	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (slen_q < mcount_q))
		else $error("safe sequence longer than membership");

endmodule

// ===== hw/rtl/bra_row_unit.sv =====
// Shared row unit: need, lane compares, saturating work-row adds and plain row add/subtract.
module bra_row_unit #(
	parameter int NRES = 5,
	parameter int UNIT_BITS = 8
) (
	input  logic [NRES-1:0][UNIT_BITS-1:0]   max_row,
	input  logic [NRES-1:0][UNIT_BITS-1:0]   held_row,
	input  logic [NRES-1:0][UNIT_BITS-1:0]   a_row,
	input  logic [NRES-1:0][UNIT_BITS+1:0]   w_row,
	output bra_pkg::row_flags_t              flags,
	output logic [NRES-1:0][UNIT_BITS+1:0]   w_plus_held,
	output logic [NRES-1:0][UNIT_BITS+1:0]   w_plus_a,
	output logic [NRES-1:0][UNIT_BITS+1:0]   w_minus_a,
	output logic [NRES-1:0][UNIT_BITS-1:0]   held_plus_a,
	output logic [NRES-1:0][UNIT_BITS-1:0]   held_minus_a
);
	import bra_pkg::*;

	localparam int FW = UNIT_BITS + 2;

	logic [UNIT_BITS-1:0] need [NRES];
	logic [FW:0]          sum_h [NRES];
	logic [FW:0]          sum_a [NRES];

	// Evaluate every resource lane side by side
	always_comb begin
		flags = '{default: 1'b1};
		for (int r = 0; r < NRES; r++) begin
			need[r] = (held_row[r] > max_row[r]) ? '0 : max_row[r] - held_row[r];
			if (a_row[r] > need[r]) flags.a_le_need = 1'b0;
			if (a_row[r] > held_row[r]) flags.a_le_held = 1'b0;
			if (FW'(a_row[r]) > w_row[r]) flags.a_le_w = 1'b0;
			if (FW'(need[r]) > w_row[r]) flags.need_le_w = 1'b0;
			sum_h[r] = {1'b0, w_row[r]} + (FW+1)'(held_row[r]);
			sum_a[r] = {1'b0, w_row[r]} + (FW+1)'(a_row[r]);
			w_plus_held[r] = sum_h[r][FW] ? {FW{1'b1}} : sum_h[r][FW-1:0];
			w_plus_a[r] = sum_a[r][FW] ? {FW{1'b1}} : sum_a[r][FW-1:0];
			w_minus_a[r] = w_row[r] - FW'(a_row[r]);
			held_plus_a[r] = held_row[r] + a_row[r];
			held_minus_a[r] = held_row[r] - a_row[r];
		end
	end

endmodule

// ===== hw/rtl/bra_result_stage.sv =====
// Result staging: holds one result back to mark the last one of a command.
module bra_result_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bra_pkg::result_t  push_res,
	input  logic              flush,
	output logic              valid,
	output bra_pkg::result_t  res
);
	import bra_pkg::*;

	logic                 pend_v_q;
	result_t              pend_q;
	logic [RES_CNT_W-1:0] cnt_q;
	result_t              pend_end;
	result_t              pend_mid;

	// Mark the held result as the final one of its command or not
	always_comb begin
		pend_end      = pend_q;
		pend_end.last = 1'b1;
		pend_mid      = pend_q;
		pend_mid.last = 1'b0;
	end

	// Forward the held result when a newer one arrives or the command ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			cnt_q    <= '0;
			valid    <= 1'b0;
			res      <= '0;
		end else begin
			valid <= 1'b0;
			if (flush) begin
				if (pend_v_q) begin
					valid <= 1'b1;
					res   <= pend_end;
				end
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end else if (push && (int'(cnt_q) < MAX_RESULTS)) begin
				if (pend_v_q) begin
					valid <= 1'b1;
					res   <= pend_mid;
				end
				pend_q   <= push_res;
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + RES_CNT_W'(1);
			end
		end
	end

endmodule
